// ----- sv/udp_icmp_protocol_swap_rewriter_core_assert.svh -----
// Assertion macros for the protocol swap rewriter core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef UDP_ICMP_PROTOCOL_SWAP_REWRITER_CORE_ASSERT_SVH
`define UDP_ICMP_PROTOCOL_SWAP_REWRITER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define URW_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urw check failed");

// Next-cycle implication, checked out of reset.
`define URW_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urw next-cycle check failed");

`endif

// ----- sv/urw_pkg.sv -----
// Shared types and constants of the protocol swap rewriter.
// No dependencies; used by the core, queue, front, back and testbench files.
`timescale 1ns / 1ps

package urw_pkg;

	// Header window geometry.
	localparam int unsigned WIN_LEN = 42;
	localparam int unsigned CNT_W   = 6;

	localparam logic [CNT_W-1:0] WIN_FULL    = CNT_W'(WIN_LEN);
	localparam logic [CNT_W-1:0] ETH_LEN     = CNT_W'(14);
	localparam logic [CNT_W-1:0] IP_MIN_LEN  = CNT_W'(28);
	localparam logic [CNT_W-1:0] ETH_TYPE_HI = CNT_W'(12);
	localparam logic [CNT_W-1:0] ETH_TYPE_LO = CNT_W'(13);

	// Offsets from the start of the IP header.
	localparam logic [CNT_W-1:0] OFF_VER      = CNT_W'(0);
	localparam logic [CNT_W-1:0] OFF_PROTO    = CNT_W'(9);
	localparam logic [CNT_W-1:0] OFF_CKS_HI   = CNT_W'(10);
	localparam logic [CNT_W-1:0] OFF_CKS_LO   = CNT_W'(11);
	localparam logic [CNT_W-1:0] OFF_SPORT_HI = CNT_W'(20);
	localparam logic [CNT_W-1:0] OFF_SPORT_LO = CNT_W'(21);
	localparam logic [CNT_W-1:0] OFF_UCKS_HI  = CNT_W'(26);
	localparam logic [CNT_W-1:0] OFF_UCKS_LO  = CNT_W'(27);

	// Protocol codes.
	localparam logic [15:0] IPV4_ETYPE     = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  IP_VERSION4    = 4'd4;
	localparam logic [15:0] MATCH_PORT_RST = 16'd6425;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PORT = 1'b1;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_BUF,
		FR_PASS,
		FR_DECIDE
	} fr_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_FLUSH
	} bk_state_t;

	typedef enum logic {
		CMD_BYTE,
		CMD_FLUSH
	} cmd_kind_t;

	typedef struct packed {
		logic        direction;
		logic [15:0] match_port;
	} cfg_t;

	// Command from the front to the back: one pass-through byte or a window flush.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       data;
		logic             last;
		logic             verdict;
		logic [CNT_W-1:0] count;
		logic             eth;
		logic             rw;
		logic [7:0]       to_proto;
		logic [15:0]      cks;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} win_wr_t;

	typedef struct packed {
		logic busy;
		logic win_done;
	} bk_status_t;

	typedef struct packed {
		logic win_busy;
		logic deciding;
	} fr_status_t;

endpackage

// ----- sv/urw_if.sv -----
// Valid/ready channel interfaces for packet bytes in and out.
// Depends on nothing.
`timescale 1ns / 1ps

interface urw_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [15:0] frame_ethertype;

	modport source(output valid, data_byte, first_byte, last_byte, frame_ethertype,
		input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, frame_ethertype,
		output ready);
endinterface

interface urw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       verdict;

	modport source(output valid, out_byte, out_last, verdict, input ready);
	modport sink(input valid, out_byte, out_last, verdict, output ready);
endinterface

// ----- sv/udp_icmp_protocol_swap_rewriter_core.sv -----
// UDP/ICMP protocol swap rewriter. Packet bytes enter at up to one per cycle.
// The first 42 bytes of a packet (or all of a shorter one) are held in a
// window memory; when the window fills or the packet ends, the front decides
// on the rewrite, and the back reads the window out at one byte per cycle
// while the output is not stalled, with the protocol byte and the IP checksum
// edited and the UDP checksum cleared in a rewritten packet. Bytes after
// the window go through a four-entry command queue, so up to four of them are
// taken in while the window drains and the input waits after that. The next
// packet's first byte waits until the previous window has been read out.
// Packets longer than the window run at one byte per cycle once it has
// drained and while the queue and the output do not stall.
// Depends on urw_pkg, urw_if, urw_front, urw_queue, urw_back and the assertion header.
`timescale 1ns / 1ps
`include "udp_icmp_protocol_swap_rewriter_core_assert.svh"

module udp_icmp_protocol_swap_rewriter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [urw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                       cfg_data,
	urw_in_if.sink                            pkt_in,
	urw_out_if.source                         pkt_out
);

	urw_pkg::cfg_t       cfg_q;
	urw_pkg::cmd_t       q_cmd, q_head;
	urw_pkg::win_wr_t    win_wr;
	urw_pkg::bk_status_t bk_status;
	urw_pkg::fr_status_t fr_status;
	logic                q_push, q_pop, q_full, q_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction  <= 1'b0;
			cfg_q.match_port <= urw_pkg::MATCH_PORT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urw_pkg::REG_DIRECTION:  cfg_q.direction  <= cfg_data[0];
				urw_pkg::REG_MATCH_PORT: cfg_q.match_port <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Byte intake and rewrite decision.
	urw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pkt_in    (pkt_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd),
		.win_wr    (win_wr),
		.bk_status (bk_status),
		.fr_status (fr_status)
	);

	// Command queue between the two sides.
	urw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Window readout and output channel.
	urw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_wr    (win_wr),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.bk_status (bk_status),
		.pkt_out   (pkt_out)
	);

	// Cross-module checks.
	`URW_CHECK(a_no_push_when_full, q_push, !q_full)
	`URW_CHECK(a_window_write_idle, win_wr.en, !bk_status.busy)
	`URW_CHECK(a_done_needs_busy, bk_status.win_done, fr_status.win_busy)
	`URW_CHECK(a_verdict_on_last, pkt_out.valid && pkt_out.verdict, pkt_out.out_last)
	`URW_CHECK_NEXT(a_done_ends_flush, bk_status.win_done, !bk_status.busy)

endmodule

// ----- sv/urw_queue.sv -----
// Short command queue between the front and the back of the rewriter.
// Depends on urw_pkg.
`timescale 1ns / 1ps

module urw_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  urw_pkg::cmd_t   push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output urw_pkg::cmd_t   head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NUM_W = $clog2(DEPTH + 1);

	urw_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [NUM_W-1:0] num_q;

	assign full      = (num_q == NUM_W'(DEPTH));
	assign not_empty = (num_q != '0);
	assign head      = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			num_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				num_q <= num_q + NUM_W'(1);
			end else if (pop && !push) begin
				num_q <= num_q - NUM_W'(1);
			end
		end
	end

endmodule

// ----- sv/urw_front.sv -----
// Front of the rewriter: takes packet bytes, fills the header window,
// captures the header fields and decides on the rewrite. Depends on urw_pkg, urw_if.
`timescale 1ns / 1ps

module urw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  urw_pkg::cfg_t       cfg,
	urw_in_if.sink              pkt_in,
	input  logic                q_full,
	output logic                q_push,
	output urw_pkg::cmd_t       q_cmd,
	output urw_pkg::win_wr_t    win_wr,
	input  urw_pkg::bk_status_t bk_status,
	output urw_pkg::fr_status_t fr_status
);

	localparam int unsigned CW = urw_pkg::CNT_W;

	urw_pkg::fr_state_t state_q, state_d, eff_state;
	logic [CW-1:0] cnt_q, cnt_d, eff_cnt;
	logic link_ipv4_q, link_ipv4_d;
	logic rewrite_q, rewrite_d;
	logic close_last_q, close_last_d;
	logic win_busy_q, win_busy_d;
	logic acc;

	// Captured header bytes, one set for each possible IP start.
	logic [7:0]  ver_q   [2];
	logic [7:0]  proto_q [2];
	logic [15:0] cks_q   [2];
	logic [15:0] port_q  [2];
	logic [7:0]  etype_hi_q;
	logic [7:0]  etype_lo_q;

	// Decision terms.
	logic        eth, len_ok, rw;
	logic [7:0]  from_proto, to_proto;
	logic [17:0] csum;
	logic [16:0] fold1, fold2;
	logic [15:0] new_cks;

	assign pkt_in.ready = !q_full && (state_q != urw_pkg::FR_DECIDE)
		&& !(win_busy_q && pkt_in.first_byte);
	assign acc = pkt_in.valid && pkt_in.ready;

	assign fr_status.win_busy = win_busy_q;
	assign fr_status.deciding = (state_q == urw_pkg::FR_DECIDE);

	// Rewrite decision and incremental checksum over the captured fields.
	always_comb begin
		eth = (cnt_q >= urw_pkg::ETH_LEN) && (etype_hi_q == urw_pkg::IPV4_ETYPE[15:8])
			&& (etype_lo_q == urw_pkg::IPV4_ETYPE[7:0]);
		len_ok = eth ? (cnt_q >= urw_pkg::ETH_LEN + urw_pkg::IP_MIN_LEN)
			: (cnt_q >= urw_pkg::IP_MIN_LEN);
		from_proto = cfg.direction ? urw_pkg::PROTO_UDP : urw_pkg::PROTO_ICMP;
		to_proto   = cfg.direction ? urw_pkg::PROTO_ICMP : urw_pkg::PROTO_UDP;
		rw = link_ipv4_q && len_ok && (ver_q[eth][7:4] == urw_pkg::IP_VERSION4)
			&& (proto_q[eth] == from_proto) && (port_q[eth] == cfg.match_port);
		csum = {2'b00, ~cks_q[eth]} + {2'b00, ~{8'h00, from_proto}} + {10'd0, to_proto};
		fold1 = {1'b0, csum[15:0]} + {15'd0, csum[17:16]};
		fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
		new_cks = ~fold2[15:0];
	end

	// Next state and outputs of the byte sequencer.
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		link_ipv4_d  = link_ipv4_q;
		rewrite_d    = rewrite_q;
		close_last_d = close_last_q;
		win_busy_d   = win_busy_q;
		q_push       = 1'b0;
		q_cmd        = '0;
		win_wr       = '0;
		eff_state    = pkt_in.first_byte ? urw_pkg::FR_BUF : state_q;
		eff_cnt      = pkt_in.first_byte ? '0 : cnt_q;

		if (bk_status.win_done) begin
			win_busy_d = 1'b0;
		end

		unique case (state_q) inside
			urw_pkg::FR_DECIDE: begin
				if (!q_full) begin
					q_push         = 1'b1;
					q_cmd.kind     = urw_pkg::CMD_FLUSH;
					q_cmd.count    = cnt_q;
					q_cmd.eth      = eth;
					q_cmd.rw       = rw;
					q_cmd.to_proto = to_proto;
					q_cmd.cks      = new_cks;
					q_cmd.last     = close_last_q;
					rewrite_d      = rw;
					win_busy_d     = 1'b1;
					state_d        = close_last_q ? urw_pkg::FR_IDLE : urw_pkg::FR_PASS;
				end
			end
			urw_pkg::FR_IDLE, urw_pkg::FR_BUF, urw_pkg::FR_PASS: begin
				if (acc) begin
					if (pkt_in.first_byte) begin
						link_ipv4_d = (pkt_in.frame_ethertype == urw_pkg::IPV4_ETYPE);
						rewrite_d   = 1'b0;
					end
					case (eff_state)
						urw_pkg::FR_PASS: begin
							q_push        = 1'b1;
							q_cmd.kind    = urw_pkg::CMD_BYTE;
							q_cmd.data    = pkt_in.data_byte;
							q_cmd.last    = pkt_in.last_byte;
							q_cmd.verdict = pkt_in.last_byte && rewrite_q;
							if (pkt_in.last_byte) begin
								state_d = urw_pkg::FR_IDLE;
							end
						end
						urw_pkg::FR_BUF: begin
							win_wr.en    = 1'b1;
							win_wr.addr  = eff_cnt;
							win_wr.data  = pkt_in.data_byte;
							cnt_d        = eff_cnt + CW'(1);
							close_last_d = pkt_in.last_byte;
							if (pkt_in.last_byte || (cnt_d == urw_pkg::WIN_FULL)) begin
								state_d = urw_pkg::FR_DECIDE;
							end else begin
								state_d = urw_pkg::FR_BUF;
							end
						end
						default: begin
							state_d = state_q;
						end
					endcase
				end
			end
			default: begin
				state_d = urw_pkg::FR_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= urw_pkg::FR_IDLE;
			cnt_q        <= '0;
			link_ipv4_q  <= 1'b0;
			rewrite_q    <= 1'b0;
			close_last_q <= 1'b0;
			win_busy_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			link_ipv4_q  <= link_ipv4_d;
			rewrite_q    <= rewrite_d;
			close_last_q <= close_last_d;
			win_busy_q   <= win_busy_d;
		end
	end

	// Capture the header bytes the decision needs as they enter the window.
	always_ff @(posedge clk) begin
		logic [CW-1:0] base;
		if (win_wr.en) begin
			if (win_wr.addr == urw_pkg::ETH_TYPE_HI) begin
				etype_hi_q <= win_wr.data;
			end
			if (win_wr.addr == urw_pkg::ETH_TYPE_LO) begin
				etype_lo_q <= win_wr.data;
			end
			for (int k = 0; k < 2; k++) begin
				base = (k == 1) ? urw_pkg::ETH_LEN : '0;
				if (win_wr.addr == base + urw_pkg::OFF_VER) begin
					ver_q[k] <= win_wr.data;
				end
				if (win_wr.addr == base + urw_pkg::OFF_PROTO) begin
					proto_q[k] <= win_wr.data;
				end
				if (win_wr.addr == base + urw_pkg::OFF_CKS_HI) begin
					cks_q[k][15:8] <= win_wr.data;
				end
				if (win_wr.addr == base + urw_pkg::OFF_CKS_LO) begin
					cks_q[k][7:0] <= win_wr.data;
				end
				if (win_wr.addr == base + urw_pkg::OFF_SPORT_HI) begin
					port_q[k][15:8] <= win_wr.data;
				end
				if (win_wr.addr == base + urw_pkg::OFF_SPORT_LO) begin
					port_q[k][7:0] <= win_wr.data;
				end
			end
		end
	end

endmodule

// ----- sv/urw_back.sv -----
// Back of the rewriter: holds the header window memory, reads it out with the
// header edits applied and drives the output channel. Depends on urw_pkg, urw_if.
`timescale 1ns / 1ps

module urw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  urw_pkg::win_wr_t    win_wr,
	input  logic                q_valid,
	input  urw_pkg::cmd_t       q_head,
	output logic                q_pop,
	output urw_pkg::bk_status_t bk_status,
	urw_out_if.source           pkt_out
);

	localparam int unsigned CW = urw_pkg::CNT_W;

	urw_pkg::bk_state_t state_q, state_d;
	urw_pkg::cmd_t      flush_q, flush_d;
	logic [CW-1:0]      idx_q, idx_d;

	logic [7:0] win_mem [urw_pkg::WIN_LEN];

	// Read stage and output register.
	logic       s1_valid_q;
	logic       s1_use_mem_s1, s1_last_s1, s1_verdict_s1;
	logic [7:0] s1_val_s1, rd_data_s1;
	logic       out_valid_q, out_last_q, out_verdict_q;
	logic [7:0] out_byte_q;

	logic          s1_move, issue_ok, issue_new, issue_rd, done;
	logic          n_use_mem, n_last, n_verdict, last_i, in_ip;
	logic [7:0]    n_val;
	logic [CW-1:0] base, rel;

	assign s1_move  = !out_valid_q || pkt_out.ready;
	assign issue_ok = !s1_valid_q || s1_move;

	assign bk_status.busy     = (state_q == urw_pkg::BK_FLUSH);
	assign bk_status.win_done = done;

	assign pkt_out.valid    = out_valid_q;
	assign pkt_out.out_byte = out_byte_q;
	assign pkt_out.out_last = out_last_q;
	assign pkt_out.verdict  = out_verdict_q;

	// Position of the current window byte relative to the IP header.
	assign base   = flush_q.eth ? urw_pkg::ETH_LEN : '0;
	assign in_ip  = (idx_q >= base);
	assign rel    = idx_q - base;
	assign last_i = ((idx_q + CW'(1)) == flush_q.count);

	// Next state: pop commands and issue one byte per cycle into the read stage while it can take one.
	always_comb begin
		state_d   = state_q;
		flush_d   = flush_q;
		idx_d     = idx_q;
		q_pop     = 1'b0;
		issue_new = 1'b0;
		issue_rd  = 1'b0;
		done      = 1'b0;
		n_use_mem = 1'b0;
		n_val     = '0;
		n_last    = 1'b0;
		n_verdict = 1'b0;

		unique case (state_q)
			urw_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (q_head.kind == urw_pkg::CMD_FLUSH) begin
						q_pop   = 1'b1;
						flush_d = q_head;
						idx_d   = '0;
						state_d = urw_pkg::BK_FLUSH;
					end else if (issue_ok) begin
						q_pop     = 1'b1;
						issue_new = 1'b1;
						n_val     = q_head.data;
						n_last    = q_head.last;
						n_verdict = q_head.verdict;
					end
				end
			end
			urw_pkg::BK_FLUSH: begin
				if (issue_ok) begin
					issue_new = 1'b1;
					issue_rd  = 1'b1;
					n_use_mem = 1'b1;
					n_last    = flush_q.last && last_i;
					n_verdict = flush_q.last && last_i && flush_q.rw;
					// Header edits of a rewritten packet.
					if (flush_q.rw && in_ip) begin
						case (rel)
							urw_pkg::OFF_PROTO: begin
								n_use_mem = 1'b0;
								n_val     = flush_q.to_proto;
							end
							urw_pkg::OFF_CKS_HI: begin
								n_use_mem = 1'b0;
								n_val     = flush_q.cks[15:8];
							end
							urw_pkg::OFF_CKS_LO: begin
								n_use_mem = 1'b0;
								n_val     = flush_q.cks[7:0];
							end
							urw_pkg::OFF_UCKS_HI, urw_pkg::OFF_UCKS_LO: begin
								n_use_mem = 1'b0;
								n_val     = '0;
							end
							default: begin
								n_use_mem = 1'b1;
							end
						endcase
					end
					idx_d = idx_q + CW'(1);
					if (last_i) begin
						done    = 1'b1;
						state_d = urw_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = urw_pkg::BK_IDLE;
			end
		endcase
	end

	// Window memory: written by the front, read here with a registered port.
	always_ff @(posedge clk) begin
		if (win_wr.en) begin
			win_mem[win_wr.addr] <= win_wr.data;
		end
		if (issue_rd) begin
			rd_data_s1 <= win_mem[idx_q];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= urw_pkg::BK_IDLE;
			idx_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (issue_ok) begin
				s1_valid_q <= issue_new;
			end
			if (s1_move) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Payload registers of the read stage and the output.
	always_ff @(posedge clk) begin
		flush_q <= flush_d;
		if (issue_new) begin
			s1_use_mem_s1 <= n_use_mem;
			s1_val_s1     <= n_val;
			s1_last_s1    <= n_last;
			s1_verdict_s1 <= n_verdict;
		end
		if (s1_move && s1_valid_q) begin
			out_byte_q    <= s1_use_mem_s1 ? rd_data_s1 : s1_val_s1;
			out_last_q    <= s1_last_s1;
			out_verdict_q <= s1_verdict_s1;
		end
	end

endmodule

// ----- tb/sv/udp_icmp_protocol_swap_rewriter_core_test.sv -----
// Self-checking testbench for the UDP/ICMP protocol swap rewriter core.
// Drives packet bytes through urw_in_if and predicts each output byte; needs urw_pkg,
// urw_if and the core.
`timescale 1ns / 1ps

module udp_icmp_protocol_swap_rewriter_core_test;

	localparam int unsigned LIMIT_CYCLES  = 200000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned IDLE_PCT      = 22;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       verdict;
	} out_beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [urw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;
	logic                          sink_ready = 1'b0;
	bit                            calm = 1'b0;

	// Predicted block state and register copies.
	logic [7:0]         hdr_win [urw_pkg::WIN_LEN];
	int unsigned        hdr_cnt;
	urw_pkg::fr_state_t rx_phase;
	logic               rx_ipv4;
	logic               rx_rewrite;
	logic               cur_dir;
	logic [15:0]        cur_port;
	out_beat_t          expected_bytes[$];

	int unsigned mismatch_count = 0;
	int unsigned results_seen   = 0;
	int unsigned rewrites_seen  = 0;
	int unsigned packets_sent   = 0;
	int unsigned packet_items   = 0;
	int unsigned cycle_count    = 0;

	urw_in_if  pkt_in ();
	urw_out_if pkt_out ();

	assign pkt_out.ready = sink_ready;

	udp_icmp_protocol_swap_rewriter_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pkt_in   (pkt_in),
		.pkt_out  (pkt_out)
	);

	always #2 clk = ~clk;

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [7:0] match_proto();
		return cur_dir ? urw_pkg::PROTO_UDP : urw_pkg::PROTO_ICMP;
	endfunction

	// Decide on the buffered window and apply the rewrite in place.
	function automatic void decide_rewrite();
		int unsigned ip;
		logic [7:0]  from_p;
		logic [7:0]  to_p;
		logic [15:0] old_cks;
		logic [15:0] inv_old;
		logic [15:0] inv_from;
		logic [31:0] acc;
		ip = 0;
		from_p = match_proto();
		to_p = cur_dir ? urw_pkg::PROTO_ICMP : urw_pkg::PROTO_UDP;
		rx_rewrite = 1'b0;
		if (!rx_ipv4)
			return;
		if (hdr_cnt >= urw_pkg::ETH_LEN
				&& hdr_win[urw_pkg::ETH_TYPE_HI] == urw_pkg::IPV4_ETYPE[15:8]
				&& hdr_win[urw_pkg::ETH_TYPE_LO] == urw_pkg::IPV4_ETYPE[7:0])
			ip = urw_pkg::ETH_LEN;
		if (hdr_cnt < ip + urw_pkg::IP_MIN_LEN)
			return;
		if (hdr_win[ip + urw_pkg::OFF_VER][7:4] != urw_pkg::IP_VERSION4)
			return;
		if (hdr_win[ip + urw_pkg::OFF_PROTO] != from_p)
			return;
		if ({hdr_win[ip + urw_pkg::OFF_SPORT_HI], hdr_win[ip + urw_pkg::OFF_SPORT_LO]}
				!= cur_port)
			return;

		hdr_win[ip + urw_pkg::OFF_PROTO] = to_p;
		hdr_win[ip + urw_pkg::OFF_UCKS_HI] = 8'h00;
		hdr_win[ip + urw_pkg::OFF_UCKS_LO] = 8'h00;
		// Incremental ones' complement update of the IP header checksum.
		old_cks = {hdr_win[ip + urw_pkg::OFF_CKS_HI], hdr_win[ip + urw_pkg::OFF_CKS_LO]};
		inv_old = ~old_cks;
		inv_from = ~{8'h00, from_p};
		acc = inv_old + inv_from + to_p;
		acc = acc[15:0] + acc[31:16];
		acc = acc[15:0] + acc[31:16];
		hdr_win[ip + urw_pkg::OFF_CKS_HI] = ~acc[15:8];
		hdr_win[ip + urw_pkg::OFF_CKS_LO] = ~acc[7:0];
		rx_rewrite = 1'b1;
	endfunction

	// Advance the predicted state by one accepted request; returns 0 if it is ignored.
	function automatic bit predict_bytes_out(logic [7:0] data, logic first, logic last,
			logic [15:0] etype);
		logic fin;
		if (first) begin
			rx_phase = urw_pkg::FR_BUF;
			hdr_cnt = 0;
			rx_ipv4 = (etype == urw_pkg::IPV4_ETYPE);
			rx_rewrite = 1'b0;
		end else if (rx_phase != urw_pkg::FR_BUF && rx_phase != urw_pkg::FR_PASS) begin
			return 1'b0;
		end
		if (rx_phase == urw_pkg::FR_PASS) begin
			expected_bytes.push_back(out_beat_t'{data, last, last & rx_rewrite});
			if (last)
				rx_phase = urw_pkg::FR_IDLE;
			return 1'b1;
		end
		if (hdr_cnt >= urw_pkg::WIN_LEN)
			hdr_cnt = urw_pkg::WIN_LEN - 1;
		hdr_win[hdr_cnt] = data;
		hdr_cnt++;
		if (hdr_cnt < urw_pkg::WIN_LEN && !last)
			return 1'b1;
		decide_rewrite();
		for (int unsigned i = 0; i < hdr_cnt; i++) begin
			fin = last && (i + 1 == hdr_cnt);
			expected_bytes.push_back(out_beat_t'{hdr_win[i], fin, fin & rx_rewrite});
		end
		rx_phase = last ? urw_pkg::FR_IDLE : urw_pkg::FR_PASS;
		return 1'b1;
	endfunction

	function automatic void note_failure(string what, out_beat_t want, out_beat_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected byte %02h last %0b verdict %0b, got byte %02h last %0b verdict %0b",
				$time, what, want.data, want.last, want.verdict,
				got.data, got.last, got.verdict);
	endfunction

	// Compare every output byte with the oldest prediction; stall the output at random.
	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t want;
		if (arst_n && pkt_out.valid && sink_ready) begin
			got = out_beat_t'{pkt_out.out_byte, pkt_out.out_last, pkt_out.verdict};
			results_seen++;
			if (got.last && got.verdict)
				rewrites_seen++;
			if (expected_bytes.size() == 0) begin
				note_failure("unexpected byte", '0, got);
			end else begin
				want = expected_bytes.pop_front();
				if (got.data != want.data || got.last != want.last
						|| got.verdict != want.verdict)
					note_failure("byte differs", want, got);
			end
		end
		sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Send one byte request, with a random gap ahead of it.
	task automatic send_request(input logic [7:0] data, input logic first, input logic last,
			input logic [15:0] etype);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pkt_in.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_in.valid <= 1'b1;
		pkt_in.data_byte <= data;
		pkt_in.first_byte <= first;
		pkt_in.last_byte <= last;
		pkt_in.frame_ethertype <= etype;
		@(posedge clk);
		while (!pkt_in.ready)
			@(posedge clk);
		if (predict_bytes_out(data, first, last, etype))
			packet_items++;
	endtask

	task automatic send_frame(input logic [7:0] frm[$], input logic [15:0] etype, input bit close);
		for (int i = 0; i < frm.size(); i++)
			send_request(frm[i], i == 0, close && (i == frm.size() - 1),
				(i == 0) ? etype : 16'($urandom));
		packets_sent++;
	endtask

	// Random bytes with the header fields that steer the rewrite placed on top.
	function automatic void build_frame(output logic [7:0] frm[$], input bit with_eth,
			input int unsigned len, input logic [7:0] proto, input logic [15:0] sport);
		int unsigned ip;
		ip = with_eth ? urw_pkg::ETH_LEN : 0;
		frm = {};
		for (int unsigned i = 0; i < len; i++)
			frm.push_back(8'($urandom));
		if (with_eth && len > urw_pkg::ETH_TYPE_LO) begin
			frm[urw_pkg::ETH_TYPE_HI] = urw_pkg::IPV4_ETYPE[15:8];
			frm[urw_pkg::ETH_TYPE_LO] = urw_pkg::IPV4_ETYPE[7:0];
		end
		if (len > ip)
			frm[ip] = {urw_pkg::IP_VERSION4, frm[ip][3:0]};
		if (len > ip + urw_pkg::OFF_PROTO)
			frm[ip + urw_pkg::OFF_PROTO] = proto;
		if (len > ip + urw_pkg::OFF_SPORT_LO) begin
			frm[ip + urw_pkg::OFF_SPORT_HI] = sport[15:8];
			frm[ip + urw_pkg::OFF_SPORT_LO] = sport[7:0];
		end
	endfunction

	// A packet that mostly qualifies for the rewrite, with occasional flaws.
	task automatic send_well_formed(input bit close);
		logic [7:0]  frm[$];
		bit          with_eth;
		int unsigned ip;
		int unsigned len;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] etype;
		with_eth = 1'($urandom_range(1));
		ip = with_eth ? urw_pkg::ETH_LEN : 0;
		len = ip + urw_pkg::IP_MIN_LEN + $urandom_range(0, 6);
		if ($urandom_range(9) == 0)
			len += $urandom_range(10, 30);
		if ($urandom_range(9) == 0)
			len = $urandom_range(1, ip + urw_pkg::IP_MIN_LEN - 1);
		proto = ($urandom_range(4) != 0) ? match_proto() : 8'($urandom);
		sport = ($urandom_range(4) != 0) ? cur_port : 16'($urandom);
		etype = ($urandom_range(9) != 0) ? urw_pkg::IPV4_ETYPE : 16'($urandom);
		build_frame(frm, with_eth, len, proto, sport);
		if ($urandom_range(9) == 0 && len > ip)
			frm[ip] = 8'($urandom);
		if (!close)
			frm = frm[0:$urandom_range(0, len - 1)];
		send_frame(frm, etype, close);
	endtask

	// Mix of good packets, random noise and cut-off sequences.
	task automatic send_random_traffic(input int unsigned budget, input int unsigned broken_pct);
		int unsigned start;
		int unsigned kind;
		bit          open_end;
		logic [7:0]  frm[$];
		start = packet_items;
		open_end = 1'b0;
		while (packet_items - start < budget) begin
			kind = $urandom_range(99);
			if (kind >= broken_pct) begin
				send_well_formed(1'b1);
				open_end = 1'b0;
			end else if (kind < broken_pct / 2) begin
				frm = {};
				repeat ($urandom_range(1, 50))
					frm.push_back(8'($urandom));
				send_frame(frm, $urandom_range(1) ? urw_pkg::IPV4_ETYPE : 16'($urandom), 1'b1);
				// Bytes outside any packet are dropped.
				repeat ($urandom_range(0, 2))
					send_request(8'($urandom), 1'b0, 1'($urandom_range(1)), 16'($urandom));
				open_end = 1'b0;
			end else begin
				// Cut-off packet, possibly extended by a few more bytes.
				send_well_formed(1'b0);
				repeat ($urandom_range(0, 3))
					send_request(8'($urandom), 1'b0, 1'b0, 16'($urandom));
				open_end = 1'b1;
			end
		end
		// Close a packet left open so that the next register write finds nothing in flight.
		if (open_end)
			send_well_formed(1'b1);
	endtask

	// Wait until the block has drained everything that is expected.
	task automatic settle();
		pkt_in.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic configure(input logic dir, input logic [15:0] port);
		cfg_we <= 1'b1;
		cfg_index <= urw_pkg::REG_DIRECTION;
		cfg_data <= {15'h0000, dir};
		@(posedge clk);
		cfg_index <= urw_pkg::REG_MATCH_PORT;
		cfg_data <= port;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_dir = dir;
		cur_port = port;
	endtask

	// Reset settings: stray byte, one-byte packet, a rewrite, a packet cut by a new one.
	task automatic test_reset_and_specials();
		logic [7:0] frm[$];
		send_request(8'h00, 1'b0, 1'b1, urw_pkg::IPV4_ETYPE);
		send_request(8'hFF, 1'b1, 1'b1, 16'hFFFF);
		build_frame(frm, 1'b0, urw_pkg::IP_MIN_LEN, urw_pkg::PROTO_ICMP,
			urw_pkg::MATCH_PORT_RST);
		frm[urw_pkg::OFF_CKS_HI] = 8'hFF;
		frm[urw_pkg::OFF_CKS_LO] = 8'hFF;
		frm[1] = 8'h00;
		frm[2] = 8'hFF;
		send_frame(frm, urw_pkg::IPV4_ETYPE, 1'b1);
		build_frame(frm, 1'b0, 4, urw_pkg::PROTO_ICMP, urw_pkg::MATCH_PORT_RST);
		send_frame(frm, 16'h0000, 1'b0);
		build_frame(frm, 1'b0, 2, urw_pkg::PROTO_ICMP, urw_pkg::MATCH_PORT_RST);
		send_frame(frm, urw_pkg::IPV4_ETYPE, 1'b1);
	endtask

	task automatic test_icmp_to_udp();
		settle();
		configure(1'b0, 16'($urandom));
		send_random_traffic(50, 30);
	endtask

	// Full port value, no idling on either side.
	task automatic test_udp_to_icmp_unbroken();
		settle();
		configure(1'b1, 16'hFFFF);
		calm = 1'b1;
		send_random_traffic(50, 30);
		calm = 1'b0;
	endtask

	task automatic test_port_zero();
		settle();
		configure(1'b0, 16'h0000);
		send_random_traffic(35, 30);
	endtask

	task automatic test_broken_sequences();
		settle();
		configure(1'($urandom_range(1)), 16'($urandom));
		send_random_traffic(40, 70);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= urw_pkg::REG_DIRECTION;
		cfg_data <= 16'h0000;
		pkt_in.valid <= 1'b0;
		pkt_in.data_byte <= 8'h00;
		pkt_in.first_byte <= 1'b0;
		pkt_in.last_byte <= 1'b0;
		pkt_in.frame_ethertype <= 16'h0000;
		rx_phase = urw_pkg::FR_IDLE;
		hdr_cnt = 0;
		rx_ipv4 = 1'b0;
		rx_rewrite = 1'b0;
		cur_dir = 1'b0;
		cur_port = urw_pkg::MATCH_PORT_RST;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_specials();
		test_icmp_to_udp();
		test_udp_to_icmp_unbroken();
		test_port_zero();
		test_broken_sequences();
		settle();

		$display("Covered %0d packets (%0d bytes in packets) in both swap directions,",
			packets_sent, packet_items);
		$display("match ports 0 and 65535 included; %0d bytes checked, %0d rewrites seen.",
			results_seen, rewrites_seen);
		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d bytes never seen", mismatch_count,
				expected_bytes.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- udp_icmp_protocol_swap_rewriter_core.f -----
+incdir+sv
sv/urw_pkg.sv
sv/urw_if.sv
sv/urw_queue.sv
sv/urw_front.sv
sv/urw_back.sv
sv/udp_icmp_protocol_swap_rewriter_core.sv
tb/sv/udp_icmp_protocol_swap_rewriter_core_test.sv
